>>> rtl/core/ata_pkg.sv
package ata_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int N_STEPS = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;
    localparam int FRAC_BITS = 16;
    localparam int VEC_W     = 38;
    localparam int ANG_W     = 25;
    localparam int LANE_LAT  = 2 * N_STEPS + 1;

    localparam logic signed [ANG_W-1:0] RIGHT_ANGLE_FINE = ANG_W'(5898240);
    localparam logic signed [ANG_W-1:0] OUT_LIMIT        = ANG_W'(23040);
    localparam logic signed [ANG_W-1:0] ROUND_HALF       = ANG_W'(128);

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;

    typedef struct packed {
        t_vec a;
        t_vec b;
    } t_pair;

    function automatic t_ang atan_fine(input int i);
        t_ang v;
        case (i)
            0:       v = ANG_W'(2949120);
            1:       v = ANG_W'(1740967);
            2:       v = ANG_W'(919879);
            3:       v = ANG_W'(466945);
            4:       v = ANG_W'(234379);
            5:       v = ANG_W'(117304);
            6:       v = ANG_W'(58666);
            7:       v = ANG_W'(29335);
            8:       v = ANG_W'(14668);
            9:       v = ANG_W'(7334);
            10:      v = ANG_W'(3667);
            11:      v = ANG_W'(1833);
            12:      v = ANG_W'(917);
            13:      v = ANG_W'(458);
            14:      v = ANG_W'(229);
            15:      v = ANG_W'(115);
            16:      v = ANG_W'(57);
            17:      v = ANG_W'(29);
            18:      v = ANG_W'(14);
            19:      v = ANG_W'(7);
            20:      v = ANG_W'(4);
            21:      v = ANG_W'(2);
            22:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_pair cordic_step(input t_vec a, input t_vec b, input int i);
        t_pair r;
        if (!b[VEC_W-1]) begin
            r.a = a + (b >>> i);
            r.b = b - (a >>> i);
        end else begin
            r.a = a - (b >>> i);
            r.b = b + (a >>> i);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/ata_lane.sv
module ata_lane (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [15:0]       i_num,
    input  logic signed [15:0]       i_p,
    input  logic signed [15:0]       i_q,
    output logic signed [15:0]       o_angle
);
    import ata_pkg::*;

    t_vec r_ma [N_STEPS];
    t_vec r_mb [N_STEPS];
    t_vec r_na [N_STEPS];
    t_vec r_nb [N_STEPS];
    logic r_sgn [N_STEPS];
    t_vec r_aa [N_STEPS];
    t_vec r_ab [N_STEPS];
    t_ang r_ang [N_STEPS];
    logic r_zf [N_STEPS];
    logic signed [15:0] r_res;

    t_vec n_ma [N_STEPS];
    t_vec n_mb [N_STEPS];
    t_vec n_na [N_STEPS];
    t_vec n_nb [N_STEPS];
    t_vec n_aa [N_STEPS];
    t_vec n_ab [N_STEPS];
    t_ang n_ang [N_STEPS];
    logic n_zf;
    logic signed [15:0] n_res;

    function automatic t_vec widen_abs(input logic signed [15:0] v);
        t_vec e;
        e = VEC_W'(v);
        if (v[15]) begin
            e = -e;
        end
        return e <<< FRAC_BITS;
    endfunction

    t_vec m_in;
    t_vec nk_in;
    t_ang ang_c;
    t_ang ang_r;
    t_pair s;

    always_comb begin
        s = cordic_step(widen_abs(i_p), widen_abs(i_q), 0);
        n_ma[0] = s.a;
        n_mb[0] = s.b;
        s = cordic_step(widen_abs(i_num), '0, 0);
        n_na[0] = s.a;
        n_nb[0] = s.b;
        for (int i = 1; i < N_STEPS; i++) begin
            s = cordic_step(r_ma[i-1], r_mb[i-1], i);
            n_ma[i] = s.a;
            n_mb[i] = s.b;
            s = cordic_step(r_na[i-1], r_nb[i-1], i);
            n_na[i] = s.a;
            n_nb[i] = s.b;
        end

        m_in  = r_ma[N_STEPS-1];
        nk_in = r_sgn[N_STEPS-1] ? -r_na[N_STEPS-1] : r_na[N_STEPS-1];
        n_zf  = (m_in == '0) && (nk_in == '0);
        s = cordic_step(m_in, nk_in, 0);
        n_aa[0]  = s.a;
        n_ab[0]  = s.b;
        n_ang[0] = nk_in[VEC_W-1] ? -atan_fine(0) : atan_fine(0);
        for (int i = 1; i < N_STEPS; i++) begin
            s = cordic_step(r_aa[i-1], r_ab[i-1], i);
            n_aa[i]  = s.a;
            n_ab[i]  = s.b;
            n_ang[i] = r_ab[i-1][VEC_W-1] ? r_ang[i-1] - atan_fine(i)
                                          : r_ang[i-1] + atan_fine(i);
        end

        ang_c = r_ang[N_STEPS-1];
        if (ang_c > RIGHT_ANGLE_FINE) begin
            ang_c = RIGHT_ANGLE_FINE;
        end
        if (ang_c < -RIGHT_ANGLE_FINE) begin
            ang_c = -RIGHT_ANGLE_FINE;
        end
        ang_r = -((ang_c + ROUND_HALF) >>> 8);
        if (ang_r > OUT_LIMIT) begin
            ang_r = OUT_LIMIT;
        end
        if (ang_r < -OUT_LIMIT) begin
            ang_r = -OUT_LIMIT;
        end
        n_res = r_zf[N_STEPS-1] ? 16'sd0 : ang_r[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn[0] <= i_num[15];
            r_zf[0]  <= n_zf;
            for (int i = 0; i < N_STEPS; i++) begin
                r_ma[i]  <= n_ma[i];
                r_mb[i]  <= n_mb[i];
                r_na[i]  <= n_na[i];
                r_nb[i]  <= n_nb[i];
                r_aa[i]  <= n_aa[i];
                r_ab[i]  <= n_ab[i];
                r_ang[i] <= n_ang[i];
            end
            for (int i = 1; i < N_STEPS; i++) begin
                r_sgn[i] <= r_sgn[i-1];
                r_zf[i]  <= r_zf[i-1];
            end
            r_res <= n_res;
        end
    end

    assign o_angle = r_res;

endmodule

>>> rtl/core/accel_tilt_angles.sv
// Throughput: one transaction per cycle while no result is held under stall, set by two fully pipelined CORDIC lanes.
// Each lane runs N_STEPS magnitude stages, N_STEPS angle stages and one rounding stage.
// The whole pipeline holds while a result waits under stall.
// Reset is synchronous and active low; it clears the valid bits only.
module accel_tilt_angles (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_x_rotation,
    output logic signed [15:0] o_y_rotation
);
    import ata_pkg::*;

    logic                  w_adv;
    logic [LANE_LAT-1:0]   r_vld;
    logic                  r_out_vld;
    logic signed [15:0]    r_xr;
    logic signed [15:0]    r_yr;
    logic signed [15:0]    w_xr;
    logic signed [15:0]    w_yr;

    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;

    ata_lane u_lane_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_num   (i_accel_y),
        .i_p     (i_accel_x),
        .i_q     (i_accel_z),
        .o_angle (w_xr)
    );

    ata_lane u_lane_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_num   (i_accel_x),
        .i_p     (i_accel_y),
        .i_q     (i_accel_z),
        .o_angle (w_yr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[LANE_LAT-2:0], i_valid};
            r_out_vld <= r_vld[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xr <= w_xr;
            r_yr <= w_yr;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_x_rotation = r_xr;
    assign o_y_rotation = r_yr;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without a held result");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (r_vld[0] == $past(i_valid)))
        else $error("accepted transaction not entered in pipeline");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_x_rotation >= -16'sd23040 && o_x_rotation <= 16'sd23040 &&
                     o_y_rotation >= -16'sd23040 && o_y_rotation <= 16'sd23040))
        else $error("tilt angle out of range");

endmodule
